FILE: rtl/hslp_pkg.sv
// Shared types and constants for the linear-probing hash set.
package hslp_pkg;

    localparam int unsigned KEY_W = 64;
    localparam int unsigned CFG_W = 4;

    // Fibonacci multiplier; only its low address bits ever reach the slot index.
    localparam logic [KEY_W-1:0] FIB_MULT = 64'h9E37_79B9_7F4A_7C15;

    localparam logic [CFG_W-1:0] SIZE_BITS_RST = 4'd12;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_HOME,
        S_CMP
    } t_state;

    // Outcome of comparing one slot against the key being probed.
    typedef struct packed {
        logic hit;
        logic empty;
    } t_cmp_res;

endpackage

FILE: rtl/hslp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hslp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/hslp_hash.sv
// Registered multiplicative hash: low address bits of key times the golden-ratio constant.
module hslp_hash
    import hslp_pkg::*;
#(
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_key_lo,
    output logic [AW-1:0] o_hash
);

    // low AW bits of a product depend only on the low AW bits of each operand
    localparam logic [AW-1:0] MULT_LO = FIB_MULT[AW-1:0];

    logic [2*AW-1:0] prod;
    logic [AW-1:0]   r_hash;

    assign prod = {{AW{1'b0}}, i_key_lo} * {{AW{1'b0}}, MULT_LO};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hash <= prod[AW-1:0];
        end
    end

    assign o_hash = r_hash;

endmodule

FILE: rtl/hslp_cmp.sv
// Slot compare unit: key match and empty-slot test, shared by every probe.
module hslp_cmp
    import hslp_pkg::*;
(
    input  logic [KEY_W-1:0] i_slot,
    input  logic [KEY_W-1:0] i_key,
    output t_cmp_res         o_res
);

    always_comb begin
        o_res.hit   = (i_slot == i_key);
        o_res.empty = (i_slot == '0);
    end

endmodule

FILE: rtl/hash_set_linear_probe.sv
// Top level of the open-addressing hash set with linear probing.
//
// Usage notes
// - Command channel: a transaction is taken at a rising edge with i_start high
//   and o_busy low. i_op selects insert (0) or lookup (1); i_key is the key.
// - Result channel: o_done pulses for one cycle with o_present, o_inserted and
//   o_full_res. The receiver cannot stall; results must be sampled on the pulse.
// - Config: i_cfg_we / i_cfg_wdata write size_bits (log2 of slots in use). The
//   user must write only while the block is idle; the block itself does not
//   check this. Zero acts as 1; values beyond the table are lowered to the
//   largest size that fits.
// - Sequence: a key of zero gets o_done in the next cycle with all flags clear.
//   Otherwise the key is hashed (S_MUL), the home slot read is issued (S_HOME),
//   then one slot is compared per cycle (S_CMP), up to every slot in use. A
//   single compare unit and the one RAM read port set this rate.
//   o_busy drops in the same cycle as o_done, so the next transaction can be
//   taken then; a key of zero does not raise o_busy at all.
// - Reset: a clearing pass writes zero to every slot with o_busy high; config
//   writes are still taken. size_bits resets to 12.
module hash_set_linear_probe
    import hslp_pkg::*;
#(
    parameter int TABLE_SLOTS = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic             i_op,
    input  logic [KEY_W-1:0] i_key,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output logic             o_done,
    output logic             o_present,
    output logic             o_inserted,
    output logic             o_full_res
);

    localparam int AW       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    // log2 of the largest power of two that fits in the table
    localparam int MAX_BITS = $clog2(TABLE_SLOTS + 1) - 1;
    localparam logic [4:0]    MAX_BITS_5 = 5'(MAX_BITS);
    localparam logic [AW-1:0] LAST_SLOT  = AW'(TABLE_SLOTS - 1);

    t_state r_state, n_state;

    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic [KEY_W-1:0] r_key,  n_key;
    logic             r_op,   n_op;
    logic [AW-1:0]    r_addr, n_addr;
    logic [AW-1:0]    r_probes, n_probes;
    logic [CFG_W-1:0] r_size_bits;
    logic             r_done, n_done;
    logic             r_present, n_present;
    logic             r_inserted, n_inserted;
    logic             r_full, n_full;

    logic             accept;
    logic [4:0]       eff_bits;
    logic [AW-1:0]    mask;
    logic [AW-1:0]    hash;
    logic [KEY_W-1:0] slot_data;
    t_cmp_res         cmp;
    logic             probe_end;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [KEY_W-1:0] ram_wdata;

    assign accept = i_start && (r_state == S_IDLE);

    // effective table size: zero means 1, clamp to what the table holds
    always_comb begin
        if (r_size_bits == '0) begin
            eff_bits = 5'd1;
        end else if ({1'b0, r_size_bits} > MAX_BITS_5) begin
            eff_bits = MAX_BITS_5;
        end else begin
            eff_bits = {1'b0, r_size_bits};
        end
        for (int i = 0; i < AW; i++) begin
            mask[i] = (5'(i) < eff_bits);
        end
    end

    hslp_hash #(
        .AW (AW)
    ) u_hash (
        .i_clk    (i_clk),
        .i_en     (r_state == S_MUL),
        .i_key_lo (r_key[AW-1:0]),
        .o_hash   (hash)
    );

    hslp_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_addr),
        .o_rdata (slot_data)
    );

    hslp_cmp u_cmp (
        .i_slot (slot_data),
        .i_key  (r_key),
        .o_res  (cmp)
    );

    // probing stops at a match, an empty slot, or after every slot in use has been probed
    assign probe_end = cmp.hit || cmp.empty || (r_probes == mask);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_addr == LAST_SLOT) n_state = S_IDLE;
            S_IDLE:  if (accept && (i_key != '0)) n_state = S_MUL;
            S_MUL:   n_state = S_HOME;
            S_HOME:  n_state = S_CMP;
            S_CMP:   if (probe_end) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_clr_addr = r_clr_addr;
        n_key      = r_key;
        n_op       = r_op;
        n_addr     = r_addr;
        n_probes   = r_probes;
        n_done     = 1'b0;
        n_present  = 1'b0;
        n_inserted = 1'b0;
        n_full     = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = r_key;
        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    n_key = i_key;
                    n_op  = i_op;
                    // key zero is never stored: answer at once, all flags clear
                    if (i_key == '0) begin
                        n_done = 1'b1;
                    end
                end
            end
            S_MUL: begin
            end
            S_HOME: begin
                n_addr   = hash & mask;
                n_probes = '0;
            end
            S_CMP: begin
                if (cmp.hit) begin
                    n_done    = 1'b1;
                    n_present = 1'b1;
                end else if (cmp.empty) begin
                    n_done = 1'b1;
                    if (r_op == OP_INSERT) begin
                        ram_we     = 1'b1;
                        n_inserted = 1'b1;
                    end
                end else if (r_probes == mask) begin
                    n_done = 1'b1;
                    n_full = 1'b1;
                end else begin
                    n_addr   = (r_addr + 1'b1) & mask;
                    n_probes = r_probes + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_size_bits <= SIZE_BITS_RST;
            r_done      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_done     <= n_done;
            if (i_cfg_we) begin
                r_size_bits <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_op       <= n_op;
        r_addr     <= n_addr;
        r_probes   <= n_probes;
        r_present  <= n_present;
        r_inserted <= n_inserted;
        r_full     <= n_full;
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_done     = r_done;
    assign o_present  = r_present;
    assign o_inserted = r_inserted;
    assign o_full_res = r_full;

`ifndef NO_ASSERTIONS
    // at most one outcome flag per result
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $onehot0({o_present, o_inserted, o_full_res}))
        else $error("more than one outcome flag on a result");

    // an insert result always follows a slot write in the cycle before
    a_insert_wrote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_inserted) |-> $past(ram_we && (r_state == S_CMP)))
        else $error("insert reported without a slot write");

    // the probe count never runs past the slots in use
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ((r_probes & ~mask) == '0))
        else $error("probe count beyond table mask");

    // a probe that ends always finishes with a result and a return to idle
    a_cmp_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CMP) && probe_end) |=> (o_done && (r_state == S_IDLE)))
        else $error("probe ended without a result");
`endif

endmodule

FILE: sim/hash_set_linear_probe_test.sv
// Self-checking testbench for the linear-probing hash set: directed and random traffic.
module hash_set_linear_probe_test
    import hslp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS       = 4096;
    localparam int unsigned SLOT_AW     = $clog2(SLOTS);
    localparam int unsigned ITEM_COUNT  = 800;
    // No transaction for this many cycles means the block has hung. The
    // clearing pass and a probe of every slot both fit well inside.
    localparam int unsigned STALL_LIMIT = 5 * SLOTS;
    localparam int unsigned POOL_DEPTH  = 32;

    // Flags of one lookup or insert outcome
    typedef struct packed {
        logic present;
        logic inserted;
        logic full_res;
    } t_probe_outcome;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    logic             i_op;
    logic [KEY_W-1:0] i_key;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic             o_done;
    logic             o_present;
    logic             o_inserted;
    logic             o_full_res;

    // Shadow of the slot table, advanced once per accepted transaction, and of size_bits
    logic [KEY_W-1:0] shadow_slots [SLOTS];
    logic [CFG_W-1:0] shadow_size_bits;

    t_probe_outcome   pending_outcomes[$];
    logic [KEY_W-1:0] recent_keys[$];
    int unsigned      fault_count;
    int unsigned      quiet_cycles;

    hash_set_linear_probe #(
        .TABLE_SLOTS (SLOTS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_present   (o_present),
        .o_inserted  (o_inserted),
        .o_full_res  (o_full_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Walk the shadow table exactly as the block should: Fibonacci home slot,
    // linear probe with wrap, stop on the key, on an empty slot or after every
    // slot in use. Inserts update the shadow table.
    function automatic t_probe_outcome probe_shadow(input logic op, input logic [KEY_W-1:0] key);
        t_probe_outcome     res;
        logic [KEY_W-1:0]   product;
        int unsigned        bits;
        int unsigned        span;
        logic [SLOT_AW-1:0] mask;
        logic [SLOT_AW-1:0] slot;
        logic               settled;
        res = '0;
        if (key != '0) begin
            // zero acts as 1; oversize values clamp to the physical table
            bits = 32'(shadow_size_bits);
            if (bits == 0)
                bits = 1;
            while (bits > 1 && (1 << bits) > SLOTS)
                bits--;
            span    = 1 << bits;
            mask    = SLOT_AW'(span - 1);
            product = key * FIB_MULT;
            slot    = product[SLOT_AW-1:0] & mask;
            settled = 1'b0;
            for (int unsigned probes = 0; probes < span && !settled; probes++) begin
                if (shadow_slots[slot] == key) begin
                    res.present = 1'b1;
                    settled     = 1'b1;
                end else if (shadow_slots[slot] == '0) begin
                    if (op == OP_INSERT) begin
                        shadow_slots[slot] = key;
                        res.inserted       = 1'b1;
                    end
                    settled = 1'b1;
                end else begin
                    slot = (slot + 1'b1) & mask;
                end
            end
            if (!settled)
                res.full_res = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        if (k == '0)
            k = 64'd1;
        return k;
    endfunction

    // Present one command and hold it until the block takes it. Called and
    // returns at a falling edge; i_start is left high so back-to-back
    // transactions need no extra edge.
    task automatic send_command(input logic op, input logic [KEY_W-1:0] key);
        i_start <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        pending_outcomes.push_back(probe_shadow(op, key));
        if (key != '0) begin
            recent_keys.push_back(key);
            if (recent_keys.size() > POOL_DEPTH)
                void'(recent_keys.pop_front());
        end
        @(negedge i_clk);
    endtask

    // Sender gap; n must be at least one
    task automatic hold_off(input int unsigned n);
        i_start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Drain every outstanding result, then write size_bits while the block is idle
    task automatic write_size_bits(input logic [CFG_W-1:0] value);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0 || o_busy)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we         <= 1'b0;
        shadow_size_bits  = value;
    endtask

    // Insert and lookup basics at the reset size, key zero and extreme keys
    task automatic test_basic_ops();
        send_command(OP_LOOKUP, 64'd1);
        send_command(OP_INSERT, 64'd1);
        send_command(OP_INSERT, 64'd1);
        send_command(OP_LOOKUP, 64'd1);
        send_command(OP_INSERT, 64'd0);
        send_command(OP_LOOKUP, 64'd0);
        send_command(OP_INSERT, {KEY_W{1'b1}});
        send_command(OP_LOOKUP, {KEY_W{1'b1}});
        send_command(OP_LOOKUP, 64'h8000_0000_0000_0000);
        send_command(OP_INSERT, 64'h8000_0000_0000_0000);
    endtask

    // Size 0 acts as two slots: three distinct inserts must run out of room
    task automatic test_full_table(output logic [KEY_W-1:0] crowd [3]);
        write_size_bits(4'd0);
        foreach (crowd[i]) begin
            crowd[i] = fresh_key();
            send_command(OP_INSERT, crowd[i]);
        end
        send_command(OP_LOOKUP, fresh_key());
        send_command(OP_LOOKUP, 64'd1);
        send_command(OP_INSERT, 64'd0);
    endtask

    // Oversize values clamp; growing the mask leaves stored keys where they were
    task automatic test_size_limits(input logic [KEY_W-1:0] crowd [3]);
        write_size_bits(4'd15);
        send_command(OP_LOOKUP, 64'd1);
        send_command(OP_LOOKUP, {KEY_W{1'b1}});
        write_size_bits(4'd13);
        send_command(OP_INSERT, fresh_key());
        write_size_bits(4'd1);
        send_command(OP_LOOKUP, fresh_key());
        write_size_bits(4'd2);
        foreach (crowd[i])
            send_command(OP_LOOKUP, crowd[i]);
        write_size_bits(4'd12);
        send_command(OP_LOOKUP, 64'd1);
    endtask

    // Phases at random sizes, mostly small so tables fill and wrap. Keys are
    // drawn from recent history to provoke hits, fresh to fill the table, or zero.
    task automatic test_random_traffic();
        int unsigned      issued;
        int unsigned      phase_len;
        int unsigned      burst_left;
        int unsigned      pick;
        logic [CFG_W-1:0] size_pick;
        logic             op;
        logic [KEY_W-1:0] key;
        issued     = 0;
        burst_left = 0;
        while (issued < ITEM_COUNT) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                size_pick = CFG_W'($urandom_range(0, 4));
            else if (pick < 8)
                size_pick = CFG_W'($urandom_range(5, 12));
            else
                size_pick = CFG_W'($urandom_range(13, 15));
            write_size_bits(size_pick);
            phase_len = $urandom_range(10, 80);
            for (int unsigned n = 0; n < phase_len && issued < ITEM_COUNT; n++) begin
                pick = $urandom_range(0, 99);
                op   = ($urandom_range(0, 99) < 60) ? OP_INSERT : OP_LOOKUP;
                if (pick < 5)
                    key = '0;
                else if (pick < 40 && recent_keys.size() != 0)
                    key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                else
                    key = fresh_key();
                send_command(op, key);
                if (key != '0)
                    issued++;
                // bursts of random length; some gaps are zero for long unbroken runs
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    if ($urandom_range(0, 3) != 0)
                        hold_off($urandom_range(1, 12));
                end else begin
                    burst_left--;
                end
            end
        end
    endtask

    // Compare each result with the oldest outstanding expectation
    always @(posedge i_clk) begin
        t_probe_outcome want;
        if (i_rst_n && o_done) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: result with nothing outstanding: present %0b inserted %0b full %0b",
                         $time, o_present, o_inserted, o_full_res);
                fault_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_present !== want.present) begin
                    $display("%0t: present expected %0b actual %0b",
                             $time, want.present, o_present);
                    fault_count++;
                end
                if (o_inserted !== want.inserted) begin
                    $display("%0t: inserted expected %0b actual %0b",
                             $time, want.inserted, o_inserted);
                    fault_count++;
                end
                if (o_full_res !== want.full_res) begin
                    $display("%0t: full_res expected %0b actual %0b",
                             $time, want.full_res, o_full_res);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog: any command taken or result seen restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL hash_set_linear_probe");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [KEY_W-1:0] crowd [3];
        i_rst_n          = 1'b0;
        i_start          = 1'b0;
        i_op             = OP_INSERT;
        i_key            = '0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        fault_count      = 0;
        quiet_cycles     = 0;
        shadow_size_bits = SIZE_BITS_RST;
        foreach (shadow_slots[i])
            shadow_slots[i] = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // the clearing pass keeps o_busy high; the first command waits it out
        test_basic_ops();
        test_full_table(crowd);
        test_size_limits(crowd);
        test_random_traffic();

        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        // catch any stray result after the last expected one
        repeat (16) @(posedge i_clk);

        if (fault_count == 0)
            $display("PASS hash_set_linear_probe");
        else
            $display("FAIL hash_set_linear_probe");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/hslp_pkg.sv
rtl/hslp_ram.sv
rtl/hslp_hash.sv
rtl/hslp_cmp.sv
rtl/hash_set_linear_probe.sv
sim/hash_set_linear_probe_test.sv
